[design/mvn_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mvn_pkg: shared types and constants of the mesh vertex normal engine
// Op codes, fixed field widths and the request/response words of the
// ratio/root unit.
// ----------------------------------------------------------------------------
package mvn_pkg;

    // op codes of an input word
    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_FACE  = 2'd1,
        OP_READ  = 2'd2,
        OP_CLEAR = 2'd3
    } op_t;

    localparam logic KIND_FLAT   = 1'b0;
    localparam logic KIND_SMOOTH = 1'b1;

    // parameter defaults
    localparam int DEF_VERTEX_DEPTH = 1024;
    localparam int DEF_COORD_BITS   = 16;
    localparam int DEF_ACCUM_BITS   = 24;

    // fixed widths
    localparam int IDX_BITS   = 10;  // index fields
    localparam int IN_BITS    = 16;  // input coordinate fields
    localparam int NORM_BITS  = 16;  // output components, Q1.14
    localparam int RED_BITS   = 16;  // reduced magnitude
    localparam int SQ_BITS    = 32;  // square of a reduced magnitude
    localparam int L2_BITS    = 34;  // sum of three squares
    localparam int QUO_BITS   = 31;  // floor(sq * 2^30 / l2) <= 2^30
    localparam int ROOT_BITS  = 32;  // root working registers
    localparam int LO_BITS    = 15;  // rounded magnitude, <= 16384

    // request to the ratio/root unit
    typedef struct packed {
        logic                start;
        logic [SQ_BITS-1:0]  num;
        logic [L2_BITS-1:0]  den;
    } ratio_req_t;

    // response of the ratio/root unit
    typedef struct packed {
        logic                done;
        logic [LO_BITS-1:0]  mag;
    } ratio_rsp_t;

endpackage

[design/mesh_vertex_normal_engine.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mesh_vertex_normal_engine: flat and smoothed normals of a triangle mesh
// Vertex store, per-vertex normal accumulators and a sequencer around one
// multiplier and one iterative ratio/root unit.
// ----------------------------------------------------------------------------
// A word is taken when start is high and busy is low; busy stays high until
// the word is finished. After reset the block sweeps the accumulator memory
// to zero, one entry a cycle, with busy high. Vertex write and accumulator
// clear hold busy only through index reduction and dispatch. The time of a
// vertex normal read or a face is set by the ratio/root unit (for each of
// three components: a request, 31 divide steps, 16 root steps and the taking
// of the result), the normalizing pre-shift (one bit per step, up to 8 steps
// for a read and 17 for a face) and, for faces, three accumulator
// read-modify-writes. An empty accumulator or a degenerate face skips the
// pre-shift, the unit and the read-modify-writes. With VERTEX_DEPTH below
// 1024 an out-of-range index is brought into range by repeated subtraction
// of the depth. Faces and reads give one result word, shown for exactly one
// cycle with result_valid high; the receiver cannot stall it.
module mesh_vertex_normal_engine #(
    parameter int VERTEX_DEPTH = mvn_pkg::DEF_VERTEX_DEPTH,
    parameter int COORD_BITS   = mvn_pkg::DEF_COORD_BITS,
    parameter int ACCUM_BITS   = mvn_pkg::DEF_ACCUM_BITS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [1:0]                          op,
    input  logic [mvn_pkg::IDX_BITS-1:0]        vertex_index,
    input  logic [mvn_pkg::IDX_BITS-1:0]        second_index,
    input  logic [mvn_pkg::IDX_BITS-1:0]        third_index,
    input  logic signed [mvn_pkg::IN_BITS-1:0]  pos_x,
    input  logic signed [mvn_pkg::IN_BITS-1:0]  pos_y,
    input  logic signed [mvn_pkg::IN_BITS-1:0]  pos_z,
    output logic                                result_valid,
    output logic                                normal_kind,
    output logic signed [mvn_pkg::NORM_BITS-1:0] norm_x,
    output logic signed [mvn_pkg::NORM_BITS-1:0] norm_y,
    output logic signed [mvn_pkg::NORM_BITS-1:0] norm_z,
    output logic                                zero_length
);

    localparam int AW  = $clog2(VERTEX_DEPTH);
    localparam int CB  = COORD_BITS;
    localparam int AB  = ACCUM_BITS;
    localparam int DW  = CB + 1;
    localparam int PW  = 2 * DW;
    localparam int VW  = (PW + 1 > AB) ? PW + 1 : AB;
    localparam int MW  = (DW > mvn_pkg::RED_BITS + 1) ? DW : mvn_pkg::RED_BITS + 1;
    localparam int RB  = mvn_pkg::RED_BITS;
    localparam int NB  = mvn_pkg::NORM_BITS;
    localparam int IB  = mvn_pkg::IDX_BITS;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_REDUCE,
        S_DISPATCH,
        S_RDA,
        S_RDB,
        S_RDC,
        S_CAPC,
        S_DIFF,
        S_MUL,
        S_ACCCAP,
        S_MAG,
        S_SHIFT,
        S_SQ,
        S_UNIT,
        S_UWAIT,
        S_UPD_RD,
        S_UPD_WR,
        S_DONE
    } state_t;

    // memories
    logic [3*CB-1:0] vmem [VERTEX_DEPTH];
    logic [3*AB-1:0] amem [VERTEX_DEPTH];
    logic [3*CB-1:0] vm_rdata_reg;
    logic [3*AB-1:0] am_rdata_reg;

    logic            vm_we;
    logic [AW-1:0]   vm_waddr;
    logic [3*CB-1:0] vm_wdata;
    logic [AW-1:0]   vm_raddr;
    logic            am_we;
    logic [AW-1:0]   am_waddr;
    logic [3*AB-1:0] am_wdata;
    logic [AW-1:0]   am_raddr;

    // sequencer registers
    state_t                  state_reg;
    logic [AW-1:0]           clr_reg;
    mvn_pkg::op_t            op_reg;
    logic [IB-1:0]           ia_reg;
    logic [IB-1:0]           ib_reg;
    logic [IB-1:0]           ic_reg;
    logic signed [CB-1:0]    px_reg;
    logic signed [CB-1:0]    py_reg;
    logic signed [CB-1:0]    pz_reg;
    logic [3*CB-1:0]         pa_reg;
    logic [3*CB-1:0]         pb_reg;
    logic [3*CB-1:0]         pc_reg;
    logic signed [DW-1:0]    e1_reg [3];
    logic signed [DW-1:0]    e2_reg [3];
    logic signed [VW-1:0]    v_reg [3];
    logic [VW-1:0]           a_reg [3];
    logic [2:0]              sgn_reg;
    logic [mvn_pkg::SQ_BITS-1:0] sq_reg [3];
    logic [mvn_pkg::L2_BITS-1:0] l2_reg;
    logic signed [NB-1:0]    n_reg [3];
    logic [2:0]              cnt_reg;
    logic [1:0]              comp_reg;
    logic [1:0]              k_reg;
    logic                    kind_reg;
    logic                    zero_reg;
    logic                    valid_reg;

    // shared units
    logic signed [MW-1:0]    mul_a;
    logic signed [MW-1:0]    mul_b;
    logic signed [2*MW-1:0]  mul_p;
    mvn_pkg::ratio_req_t     rreq;
    mvn_pkg::ratio_rsp_t     rrsp;

    // combinational helpers
    logic                    need_wrap;
    logic                    need_shift;
    logic                    v_zero;
    logic [AW-1:0]           corner;
    logic [3*AB-1:0]         acc_sum;
    logic signed [VW-1:0]    prod_v;
    logic signed [NB-1:0]    n_new;

    mvn_mul #(
        .MW (MW)
    ) u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .a     (mul_a),
        .b     (mul_b),
        .p     (mul_p)
    );

    mvn_ratio u_ratio (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (rreq),
        .rsp   (rrsp)
    );

    // vertex store
    always_ff @(posedge clk)
    begin
        if (vm_we)
        begin
            vmem[vm_waddr] <= vm_wdata;
        end
        vm_rdata_reg <= vmem[vm_raddr];
    end

    // accumulator store
    always_ff @(posedge clk)
    begin
        if (am_we)
        begin
            amem[am_waddr] <= am_wdata;
        end
        am_rdata_reg <= amem[am_raddr];
    end

    // index wrap, shift test, zero test, corner select
    always_comb
    begin
        need_wrap = (32'(ia_reg) >= 32'(VERTEX_DEPTH)) ||
                    (32'(ib_reg) >= 32'(VERTEX_DEPTH)) ||
                    (32'(ic_reg) >= 32'(VERTEX_DEPTH));
        need_shift = (|a_reg[0][VW-1:RB]) || (|a_reg[1][VW-1:RB]) ||
                     (|a_reg[2][VW-1:RB]);
        v_zero = (v_reg[0] == '0) && (v_reg[1] == '0) && (v_reg[2] == '0);
        case (k_reg)
            2'd0:    corner = AW'(ia_reg);
            2'd1:    corner = AW'(ib_reg);
            default: corner = AW'(ic_reg);
        endcase
        prod_v = VW'(mul_p);
        n_new  = sgn_reg[comp_reg] ? -NB'({1'b0, rrsp.mag}) : NB'({1'b0, rrsp.mag});
    end

    // saturating accumulate of the face normal
    always_comb
    begin
        acc_sum = '0;
        for (int i = 0; i < 3; i++)
        begin
            logic signed [AB:0] s;
            s = (AB+1)'($signed(am_rdata_reg[i*AB +: AB])) + (AB+1)'(n_reg[i]);
            if (s[AB] != s[AB-1])
            begin
                acc_sum[i*AB +: AB] = s[AB] ? {1'b1, (AB-1)'(0)} : {1'b0, {(AB-1){1'b1}}};
            end
            else
            begin
                acc_sum[i*AB +: AB] = s[AB-1:0];
            end
        end
    end

    // memory ports
    always_comb
    begin
        vm_we    = (state_reg == S_DISPATCH) && (op_reg == mvn_pkg::OP_WRITE);
        vm_waddr = AW'(ia_reg);
        vm_wdata = {pz_reg, py_reg, px_reg};
        case (state_reg)
            S_RDB:   vm_raddr = AW'(ib_reg);
            S_RDC:   vm_raddr = AW'(ic_reg);
            default: vm_raddr = AW'(ia_reg);
        endcase

        am_we    = 1'b0;
        am_waddr = AW'(ia_reg);
        am_wdata = '0;
        case (state_reg)
            S_CLEAR:
            begin
                am_we    = 1'b1;
                am_waddr = clr_reg;
            end
            S_DISPATCH:
            begin
                am_we = (op_reg == mvn_pkg::OP_CLEAR);
            end
            S_UPD_WR:
            begin
                am_we    = 1'b1;
                am_waddr = corner;
                am_wdata = acc_sum;
            end
            default:
            begin
                am_we = 1'b0;
            end
        endcase
        am_raddr = (state_reg == S_UPD_RD) ? corner : AW'(ia_reg);
    end

    // multiplier operands
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        if (state_reg == S_MUL)
        begin
            case (cnt_reg)
                3'd0:    begin mul_a = MW'(e1_reg[1]); mul_b = MW'(e2_reg[2]); end
                3'd1:    begin mul_a = MW'(e1_reg[2]); mul_b = MW'(e2_reg[1]); end
                3'd2:    begin mul_a = MW'(e1_reg[2]); mul_b = MW'(e2_reg[0]); end
                3'd3:    begin mul_a = MW'(e1_reg[0]); mul_b = MW'(e2_reg[2]); end
                3'd4:    begin mul_a = MW'(e1_reg[0]); mul_b = MW'(e2_reg[1]); end
                3'd5:    begin mul_a = MW'(e1_reg[1]); mul_b = MW'(e2_reg[0]); end
                default: begin mul_a = '0; mul_b = '0; end
            endcase
        end
        else if (state_reg == S_SQ)
        begin
            for (int i = 0; i < 3; i++)
            begin
                if (cnt_reg == 3'(i))
                begin
                    mul_a = MW'($signed({1'b0, a_reg[i][RB-1:0]}));
                    mul_b = MW'($signed({1'b0, a_reg[i][RB-1:0]}));
                end
            end
        end
    end

    // ratio unit request
    always_comb
    begin
        rreq.start = (state_reg == S_UNIT);
        rreq.num   = sq_reg[comp_reg];
        rreq.den   = l2_reg;
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
            op_reg    <= mvn_pkg::OP_WRITE;
            ia_reg    <= '0;
            ib_reg    <= '0;
            ic_reg    <= '0;
            px_reg    <= '0;
            py_reg    <= '0;
            pz_reg    <= '0;
            pa_reg    <= '0;
            pb_reg    <= '0;
            pc_reg    <= '0;
            for (int i = 0; i < 3; i++)
            begin
                e1_reg[i] <= '0;
                e2_reg[i] <= '0;
                v_reg[i]  <= '0;
                a_reg[i]  <= '0;
                sq_reg[i] <= '0;
                n_reg[i]  <= '0;
            end
            sgn_reg   <= '0;
            l2_reg    <= '0;
            cnt_reg   <= '0;
            comp_reg  <= '0;
            k_reg     <= '0;
            kind_reg  <= mvn_pkg::KIND_FLAT;
            zero_reg  <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= 1'b0;
            case (state_reg)
                // zero every accumulator after reset
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == AW'(VERTEX_DEPTH - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (start)
                    begin
                        op_reg    <= mvn_pkg::op_t'(op);
                        ia_reg    <= vertex_index;
                        ib_reg    <= second_index;
                        ic_reg    <= third_index;
                        px_reg    <= CB'(pos_x);
                        py_reg    <= CB'(pos_y);
                        pz_reg    <= CB'(pos_z);
                        state_reg <= S_REDUCE;
                    end
                end
                // indices modulo the store depth
                S_REDUCE:
                begin
                    if (need_wrap)
                    begin
                        if (32'(ia_reg) >= 32'(VERTEX_DEPTH))
                            ia_reg <= ia_reg - IB'(VERTEX_DEPTH);
                        if (32'(ib_reg) >= 32'(VERTEX_DEPTH))
                            ib_reg <= ib_reg - IB'(VERTEX_DEPTH);
                        if (32'(ic_reg) >= 32'(VERTEX_DEPTH))
                            ic_reg <= ic_reg - IB'(VERTEX_DEPTH);
                    end
                    else
                    begin
                        state_reg <= S_DISPATCH;
                    end
                end
                S_DISPATCH:
                begin
                    case (op_reg)
                        mvn_pkg::OP_FACE:
                        begin
                            kind_reg  <= mvn_pkg::KIND_FLAT;
                            state_reg <= S_RDA;
                        end
                        mvn_pkg::OP_READ:
                        begin
                            kind_reg  <= mvn_pkg::KIND_SMOOTH;
                            state_reg <= S_ACCCAP;
                        end
                        default:
                        begin
                            state_reg <= S_IDLE;
                        end
                    endcase
                end
                // fetch three corners
                S_RDA:
                begin
                    state_reg <= S_RDB;
                end
                S_RDB:
                begin
                    pa_reg    <= vm_rdata_reg;
                    state_reg <= S_RDC;
                end
                S_RDC:
                begin
                    pb_reg    <= vm_rdata_reg;
                    state_reg <= S_CAPC;
                end
                S_CAPC:
                begin
                    pc_reg    <= vm_rdata_reg;
                    state_reg <= S_DIFF;
                end
                // edge vectors
                S_DIFF:
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        e1_reg[i] <= DW'($signed(pb_reg[i*CB +: CB])) -
                                     DW'($signed(pa_reg[i*CB +: CB]));
                        e2_reg[i] <= DW'($signed(pc_reg[i*CB +: CB])) -
                                     DW'($signed(pa_reg[i*CB +: CB]));
                    end
                    cnt_reg   <= '0;
                    state_reg <= S_MUL;
                end
                // cross product, six products
                S_MUL:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    for (int i = 0; i < 3; i++)
                    begin
                        if (cnt_reg == 3'(2*i + 1))
                            v_reg[i] <= prod_v;
                        if (cnt_reg == 3'(2*i + 2))
                            v_reg[i] <= v_reg[i] - prod_v;
                    end
                    if (cnt_reg == 3'd6)
                    begin
                        state_reg <= S_MAG;
                    end
                end
                S_ACCCAP:
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        v_reg[i] <= VW'($signed(am_rdata_reg[i*AB +: AB]));
                    end
                    state_reg <= S_MAG;
                end
                // magnitudes and signs
                S_MAG:
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        a_reg[i]   <= v_reg[i][VW-1] ? VW'(-v_reg[i]) : VW'(v_reg[i]);
                        sgn_reg[i] <= v_reg[i][VW-1];
                        n_reg[i]   <= '0;
                    end
                    if (v_zero)
                    begin
                        zero_reg  <= 1'b1;
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        zero_reg  <= 1'b0;
                        state_reg <= S_SHIFT;
                    end
                end
                // bring the largest magnitude below 2^16
                S_SHIFT:
                begin
                    if (need_shift)
                    begin
                        for (int i = 0; i < 3; i++)
                        begin
                            a_reg[i] <= a_reg[i] >> 1;
                        end
                    end
                    else
                    begin
                        cnt_reg   <= '0;
                        l2_reg    <= '0;
                        state_reg <= S_SQ;
                    end
                end
                // squares and their sum
                S_SQ:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    for (int i = 0; i < 3; i++)
                    begin
                        if (cnt_reg == 3'(i + 1))
                        begin
                            sq_reg[i] <= mul_p[mvn_pkg::SQ_BITS-1:0];
                            l2_reg    <= l2_reg +
                                mvn_pkg::L2_BITS'(mul_p[mvn_pkg::SQ_BITS-1:0]);
                        end
                    end
                    if (cnt_reg == 3'd3)
                    begin
                        comp_reg  <= '0;
                        state_reg <= S_UNIT;
                    end
                end
                S_UNIT:
                begin
                    state_reg <= S_UWAIT;
                end
                S_UWAIT:
                begin
                    if (rrsp.done)
                    begin
                        n_reg[comp_reg] <= n_new;
                        comp_reg        <= comp_reg + 1'b1;
                        if (comp_reg == 2'd2)
                        begin
                            k_reg     <= '0;
                            state_reg <= (kind_reg == mvn_pkg::KIND_FLAT) ? S_UPD_RD : S_DONE;
                        end
                        else
                        begin
                            state_reg <= S_UNIT;
                        end
                    end
                end
                // accumulate into the three corners
                S_UPD_RD:
                begin
                    state_reg <= S_UPD_WR;
                end
                S_UPD_WR:
                begin
                    k_reg <= k_reg + 1'b1;
                    state_reg <= (k_reg == 2'd2) ? S_DONE : S_UPD_RD;
                end
                S_DONE:
                begin
                    valid_reg <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign busy         = (state_reg != S_IDLE);
    assign result_valid = valid_reg;
    assign normal_kind  = kind_reg;
    assign norm_x       = n_reg[0];
    assign norm_y       = n_reg[1];
    assign norm_z       = n_reg[2];
    assign zero_length  = zero_reg;

endmodule

[design/mvn_mul.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mvn_mul: shared signed multiplier
// One registered signed product per cycle.
// ----------------------------------------------------------------------------
module mvn_mul #(
    parameter int MW = 17
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic signed [MW-1:0]   a,
    input  logic signed [MW-1:0]   b,
    output logic signed [2*MW-1:0] p
);

    logic signed [2*MW-1:0] p_reg;

    // product register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_reg <= '0;
        end
        else
        begin
            p_reg <= a * b;
        end
    end

    assign p = p_reg;

endmodule

[design/mvn_ratio.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mvn_ratio: iterative ratio and root unit
// Computes round(16384 * sqrt(num / den)) as floor((isqrt(q) + 1) / 2) with
// q = floor(num * 2^30 / den): a restoring divide, one quotient bit a cycle,
// then a digit-by-digit root, one result bit a cycle. Needs num <= den.
// ----------------------------------------------------------------------------
module mvn_ratio (
    input  logic                clk,
    input  logic                rst_n,
    input  mvn_pkg::ratio_req_t req,
    output mvn_pkg::ratio_rsp_t rsp
);

    localparam int CW = 5;

    typedef enum logic [1:0] {
        U_IDLE,
        U_DIV,
        U_ROOT
    } ustate_t;

    ustate_t                        state_reg;
    logic [mvn_pkg::L2_BITS-1:0]    rem_reg;
    logic [mvn_pkg::L2_BITS-1:0]    den_reg;
    logic [mvn_pkg::QUO_BITS-1:0]   sh_reg;
    logic [mvn_pkg::QUO_BITS-1:0]   q_reg;
    logic [mvn_pkg::ROOT_BITS-1:0]  op_reg;
    logic [mvn_pkg::ROOT_BITS-1:0]  res_reg;
    logic [mvn_pkg::ROOT_BITS-1:0]  one_reg;
    logic [CW-1:0]                  cnt_reg;
    logic                           done_reg;
    logic [mvn_pkg::LO_BITS-1:0]    mag_reg;

    // divide step
    logic [mvn_pkg::L2_BITS:0]      rem2;
    logic                           qbit;
    logic [mvn_pkg::L2_BITS-1:0]    rem_next;
    logic [mvn_pkg::QUO_BITS-1:0]   q_next;

    // root step
    logic [mvn_pkg::ROOT_BITS-1:0]  trial;
    logic                           rbit;
    logic [mvn_pkg::ROOT_BITS-1:0]  op_next;
    logic [mvn_pkg::ROOT_BITS-1:0]  res_next;
    logic [mvn_pkg::ROOT_BITS-1:0]  rnd;

    always_comb
    begin
        rem2     = {rem_reg, sh_reg[mvn_pkg::QUO_BITS-1]};
        qbit     = rem2 >= {1'b0, den_reg};
        rem_next = qbit ? mvn_pkg::L2_BITS'(rem2 - {1'b0, den_reg})
                        : mvn_pkg::L2_BITS'(rem2);
        q_next   = {q_reg[mvn_pkg::QUO_BITS-2:0], qbit};

        trial    = res_reg + one_reg;
        rbit     = op_reg >= trial;
        op_next  = rbit ? op_reg - trial : op_reg;
        res_next = rbit ? (res_reg >> 1) + one_reg : (res_reg >> 1);
        rnd      = (res_next + 1'b1) >> 1;
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= U_IDLE;
            rem_reg   <= '0;
            den_reg   <= '0;
            sh_reg    <= '0;
            q_reg     <= '0;
            op_reg    <= '0;
            res_reg   <= '0;
            one_reg   <= '0;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
            mag_reg   <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                U_IDLE:
                begin
                    if (req.start)
                    begin
                        rem_reg   <= mvn_pkg::L2_BITS'(req.num[mvn_pkg::SQ_BITS-1:1]);
                        sh_reg    <= {req.num[0], (mvn_pkg::QUO_BITS-1)'(0)};
                        den_reg   <= req.den;
                        q_reg     <= '0;
                        cnt_reg   <= '0;
                        state_reg <= U_DIV;
                    end
                end
                U_DIV:
                begin
                    rem_reg <= rem_next;
                    q_reg   <= q_next;
                    sh_reg  <= sh_reg << 1;
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == CW'(mvn_pkg::QUO_BITS - 1))
                    begin
                        op_reg    <= mvn_pkg::ROOT_BITS'(q_next);
                        res_reg   <= '0;
                        one_reg   <= mvn_pkg::ROOT_BITS'(1) << 30;
                        cnt_reg   <= '0;
                        state_reg <= U_ROOT;
                    end
                end
                U_ROOT:
                begin
                    op_reg  <= op_next;
                    res_reg <= res_next;
                    one_reg <= one_reg >> 2;
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == CW'(15))
                    begin
                        mag_reg   <= rnd[mvn_pkg::LO_BITS-1:0];
                        done_reg  <= 1'b1;
                        state_reg <= U_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= U_IDLE;
                end
            endcase
        end
    end

    assign rsp.done = done_reg;
    assign rsp.mag  = mag_reg;

endmodule
